// File: hdl/masked_byte_pattern_scanner_defines.svh
// Assertion macros for the masked byte pattern scanner.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MASKED_BYTE_PATTERN_SCANNER_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MBPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/mbps_pkg.sv
// Shared types and constants for the masked byte pattern scanner.
// No dependencies.
package mbps_pkg;

  localparam int ADDR_BITS  = 32;
  localparam int COUNT_BITS = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int PAT_REG_BYTES  = 8;

  // Result queue depth; input is taken while two slots are free.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Result kinds (travel on tuser)
  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_PAT_LO   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PAT_HI   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CARE     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEN      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX      = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BASE     = 3'd5;

  localparam logic [4:0]            LEN_RESET = 5'd1;
  localparam logic [COUNT_BITS-1:0] MAX_RESET = 16'd1;

  typedef struct packed {
    logic                  kind;
    logic [ADDR_BITS-1:0]  addr;
    logic [COUNT_BITS-1:0] count;
    logic                  last;
  } res_t;

  // Up to two results pushed per input beat
  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } q_push_t;

endpackage

// File: hdl/mbps_match.sv
// Byte window shift line and masked pattern compare.
// Depends on nothing but its parameter; one compare lane per window tap.
module mbps_match #(
  parameter int MAXP = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        shift_en,
  input  logic                        clear,
  input  logic [7:0]                  cur_byte,
  input  logic [MAXP-1:0][7:0]        pattern,
  input  logic [MAXP-1:0]             care,
  input  logic [$clog2(MAXP+1)-1:0]   len,
  output logic                        hit
);

  localparam int LENW = $clog2(MAXP + 1);
  localparam int TAPW = $clog2(MAXP);

  logic [7:0]      win_r [MAXP-1];
  logic [TAPW-1:0] fill_r;
  logic [MAXP-1:0] lane_ok;

  // Tap i holds the byte i steps back; it meets pattern byte len-1-i.
  for (genvar i = 0; i < MAXP; i++) begin : g_tap
    logic [LENW-1:0] back_idx;
    logic [TAPW-1:0] pidx;
    logic [7:0]      tap_byte;

    assign back_idx = len - LENW'(i + 1);
    assign pidx     = back_idx[TAPW-1:0];

    if (i == 0) begin : g_cur
      assign tap_byte = cur_byte;
    end else begin : g_win
      assign tap_byte = win_r[i-1];
    end

    assign lane_ok[i] = (LENW'(i) >= len) || !care[pidx] || (tap_byte == pattern[pidx]);
  end

  assign hit = (&lane_ok) && ((LENW'(fill_r) + LENW'(1)) >= len);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      win_r[0] <= cur_byte;
      for (int k = 1; k < MAXP - 1; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      fill_r <= '0;
    end else if (shift_en && fill_r != TAPW'(MAXP - 1)) begin
      fill_r <= fill_r + TAPW'(1);
    end
  end

endmodule

// File: hdl/mbps_result_queue.sv
// Small result queue: takes up to two results a cycle, gives one.
// Depends on mbps_pkg.
module mbps_result_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  mbps_pkg::q_push_t push,
  input  logic             pop_ready,
  output logic             out_valid,
  output mbps_pkg::res_t   out_data,
  output logic             room_for_two
);

  mbps_pkg::res_t                  entries_r [mbps_pkg::QDEPTH];
  logic [mbps_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [mbps_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [mbps_pkg::QCNT_W-1:0]     count_r;
  logic                            pop;

  assign out_valid    = count_r != '0;
  assign out_data     = entries_r[rd_ptr_r];
  assign pop          = out_valid && pop_ready;
  assign room_for_two = count_r <= mbps_pkg::QCNT_W'(mbps_pkg::QDEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      entries_r[wr_ptr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      entries_r[wr_ptr_r + mbps_pkg::QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + mbps_pkg::QPTR_W'(push.cnt);
      rd_ptr_r <= rd_ptr_r + mbps_pkg::QPTR_W'(pop);
      count_r  <= count_r + mbps_pkg::QCNT_W'(push.cnt) - mbps_pkg::QCNT_W'(pop);
    end
  end

endmodule

// File: hdl/masked_byte_pattern_scanner.sv
// Latency: a byte's first result is visible on out_* the cycle after its input beat
//   when the result queue is empty; queued beats ahead of it add their wait.
// Throughput: one byte per cycle while each byte yields at most one result; the
//   4-entry result queue takes in_* only with two slots free, so a run of bytes
//   with two results each, or out_tready low, throttles the input.
// Reset: rst_n synchronous, active low; clears scan state, queue, and the
//   registers (length and match limit to 1, the rest to 0).
`include "masked_byte_pattern_scanner_defines.svh"

module masked_byte_pattern_scanner #(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int POSITION_BITS     = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // final_byte
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] match_address, [47:32] match_count
  output logic        out_tuser,  // [0] result_kind
  output logic        out_tlast,  // last_of_run
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [mbps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mbps_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int LENW = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int CW   = mbps_pkg::COUNT_BITS;
  localparam int AW   = mbps_pkg::ADDR_BITS;

  // ---------------- configuration registers ----------------
  logic [63:0]   pat_lo_r;
  logic [63:0]   pat_hi_r;
  logic [15:0]   care_r;
  logic [4:0]    len_r;
  logic [CW-1:0] max_r;
  logic [AW-1:0] base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      care_r   <= '0;
      len_r    <= mbps_pkg::LEN_RESET;
      max_r    <= mbps_pkg::MAX_RESET;
      base_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbps_pkg::REG_PAT_LO: pat_lo_r <= cfg_wdata;
        mbps_pkg::REG_PAT_HI: pat_hi_r <= cfg_wdata;
        mbps_pkg::REG_CARE:   care_r   <= cfg_wdata[15:0];
        mbps_pkg::REG_LEN:    len_r    <= cfg_wdata[4:0];
        mbps_pkg::REG_MAX:    max_r    <= cfg_wdata[CW-1:0];
        mbps_pkg::REG_BASE:   base_r   <= cfg_wdata[AW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Effective length: zero acts as one, anything past the window top clamps.
  logic [LENW-1:0] len_eff;

  always_comb begin
    if (len_r == 5'd0) begin
      len_eff = LENW'(1);
    end else if (len_r > 5'(MAX_PATTERN_BYTES)) begin
      len_eff = LENW'(MAX_PATTERN_BYTES);
    end else begin
      len_eff = LENW'(len_r);
    end
  end

  // Pattern bytes as lanes; bytes past MAX_PATTERN_BYTES are never used.
  logic [127:0]                        pat_all;
  logic [MAX_PATTERN_BYTES-1:0][7:0]   pat_lanes;

  assign pat_all = {pat_hi_r, pat_lo_r};

  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_pat
    assign pat_lanes[i] = pat_all[i*8 +: 8];
  end

  // ---------------- scan state ----------------
  logic                     in_fire;
  logic                     hit;
  logic                     report;
  logic [POSITION_BITS-1:0] pos_r;
  logic [CW-1:0]            found_r;
  logic [CW-1:0]            found_inc;
  logic [POSITION_BITS-1:0] start_pos;
  logic                     q_room;
  mbps_pkg::q_push_t        push;
  mbps_pkg::res_t           m_res;
  mbps_pkg::res_t           s_res;
  mbps_pkg::res_t           q_head;

  assign in_tready = q_room;
  assign in_fire   = in_tvalid && in_tready;

  mbps_match #(
    .MAXP (MAX_PATTERN_BYTES)
  ) u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (in_fire && !in_tlast),
    .clear    (in_fire && in_tlast),
    .cur_byte (in_tdata),
    .pattern  (pat_lanes),
    .care     (care_r[MAX_PATTERN_BYTES-1:0]),
    .len      (len_eff),
    .hit      (hit)
  );

  // A hit counts only while under the per-scan limit.
  assign report    = hit && (found_r < max_r);
  assign found_inc = found_r + CW'(1);

  // Match starts len-1 bytes before the current one; wraps with the position.
  assign start_pos = pos_r - POSITION_BITS'(len_eff - LENW'(1));

  always_comb begin
    m_res.kind  = mbps_pkg::KIND_MATCH;
    m_res.addr  = base_r + AW'(start_pos);
    m_res.count = found_inc;
    m_res.last  = !in_tlast;

    s_res.kind  = mbps_pkg::KIND_SUMMARY;
    s_res.addr  = '0;
    s_res.count = report ? found_inc : found_r;
    s_res.last  = 1'b1;

    push.cnt    = 2'd0;
    push.first  = m_res;
    push.second = s_res;
    if (in_fire) begin
      priority if (report && in_tlast) begin
        push.cnt = 2'd2;
      end else if (report) begin
        push.cnt = 2'd1;
      end else if (in_tlast) begin
        push.cnt   = 2'd1;
        push.first = s_res;
      end else begin
        push.cnt = 2'd0;  // plain byte, nothing to report
      end
    end
  end

  // Position and match count; both return to zero after the final byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      found_r <= '0;
    end else if (in_fire) begin
      if (in_tlast) begin
        pos_r   <= '0;
        found_r <= '0;
      end else begin
        pos_r <= pos_r + POSITION_BITS'(1);
        if (report) begin
          found_r <= found_inc;
        end
      end
    end
  end

  // ---------------- result queue ----------------
  mbps_result_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .pop_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_data     (q_head),
    .room_for_two (q_room)
  );

  assign out_tdata = {q_head.count, q_head.addr};
  assign out_tuser = q_head.kind;
  assign out_tlast = q_head.last;

  // ---------------- checks ----------------
  `MBPS_ASSERT_NEXT(a_scan_restart, in_fire && in_tlast, found_r == '0 && pos_r == '0, "scan state not cleared after final byte")
  `MBPS_ASSERT_NEXT(a_summary_queued, in_fire && in_tlast, out_tvalid, "summary not queued after final byte")
  `MBPS_ASSERT_NOW(a_match_count_nonzero, out_tvalid && out_tuser == mbps_pkg::KIND_MATCH, out_tdata[47:32] != '0, "match result with zero count")

endmodule

// File: dv/masked_byte_pattern_scanner_tb.sv
// Testbench for masked_byte_pattern_scanner: streams byte images and checks every
// match and end-of-scan summary against a cycle-free predictor of the scanner, or typed script beats.
// Depends on mbps_pkg (register indexes, result kinds, res_t) and the scanner RTL.
module masked_byte_pattern_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int             MAX_SPAN     = 16;    // pattern bytes the block supports
  localparam int             HIST_DEPTH   = MAX_SPAN - 1;
  localparam int             RANDOM_BYTES = 1500;
  localparam int             QUIET_TAIL   = 200;   // last bytes sent with no idling at all
  localparam int             SETTLE_CYC   = 4;     // margin after the last expected beat is back
  localparam int             PRINT_CAP    = 100;
  localparam mbps_pkg::res_t NO_RES       = '0;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] data_byte
  logic        in_tlast;    // final_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;   // [31:0] match_address, [47:32] match_count
  logic        out_tuser;   // [0] result_kind
  logic        out_tlast;   // last_of_run
  logic                                cfg_we;
  logic [mbps_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [mbps_pkg::CFG_DATA_BITS-1:0]  cfg_wdata;

  always #5 clk = ~clk;

  masked_byte_pattern_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Scanner predictor: register copies and scan state
  // ---------------------------------------------------------------------------
  logic [63:0]                     pat_lo_r;
  logic [63:0]                     pat_hi_r;
  logic [15:0]                     care_r;
  logic [4:0]                      len_r;
  logic [mbps_pkg::COUNT_BITS-1:0] max_r;
  logic [mbps_pkg::ADDR_BITS-1:0]  base_r;

  logic [7:0]                      history [HIST_DEPTH];  // [0] is the newest earlier byte
  logic [31:0]                     scan_pos;
  logic [mbps_pkg::COUNT_BITS-1:0] hits_reported;
  int unsigned                     window_fill;

  mbps_pkg::res_t awaited_results [$];
  int unsigned    mismatches = 0;
  bit             idling_on  = 1'b1;
  int unsigned    plant_at   = MAX_SPAN;   // index into a pattern copy being planted

  // Out-of-range lengths clamp: 0 acts as 1, above 16 acts as 16.
  function automatic int unsigned pattern_span();
    if (len_r == 0) return 1;
    if (len_r > MAX_SPAN) return MAX_SPAN;
    return int'(len_r);
  endfunction

  function automatic logic [7:0] pattern_byte(input int unsigned j);
    logic [127:0] both;
    both = {pat_hi_r, pat_lo_r};
    return both[8*j +: 8];
  endfunction

  function automatic void restart_scan();
    foreach (history[k]) history[k] = 8'h00;
    scan_pos      = '0;
    hits_reported = '0;
    window_fill   = 0;
  endfunction

  // Results caused by one input beat; returns how many (0..2).
  function automatic int scan_byte_results(input logic [7:0] cur, input logic fin,
                                           output mbps_pkg::res_t first,
                                           output mbps_pkg::res_t second);
    int unsigned                    span;
    int unsigned                    j;
    int unsigned                    back;
    bit                             hit;
    logic [7:0]                     seen;
    logic [mbps_pkg::ADDR_BITS-1:0] start_addr;
    mbps_pkg::res_t                 got [2];
    int                             n;
    span   = pattern_span();
    n      = 0;
    got[0] = NO_RES;
    got[1] = NO_RES;
    // a match must lie wholly inside the current image
    if (window_fill + 1 >= span) begin
      hit = 1'b1;
      for (j = 0; j < span; j++) begin
        back = span - 1 - j;
        seen = (back == 0) ? cur : history[back-1];
        if (care_r[j] && seen != pattern_byte(j)) hit = 1'b0;
      end
      // past the limit, hits are neither reported nor counted
      if (hit && hits_reported < max_r) begin
        hits_reported = hits_reported + 1'b1;
        start_addr    = base_r + scan_pos - 32'(span - 1);
        got[n]        = '{mbps_pkg::KIND_MATCH, start_addr, hits_reported, 1'b0};
        n++;
      end
    end
    if (fin) begin
      got[n] = '{mbps_pkg::KIND_SUMMARY, 32'h0, hits_reported, 1'b0};
      n++;
      restart_scan();
    end else begin
      for (j = HIST_DEPTH - 1; j > 0; j--) history[j] = history[j-1];
      history[0] = cur;
      if (window_fill < HIST_DEPTH) window_fill++;
      scan_pos = scan_pos + 1'b1;
    end
    if (n > 0) got[n-1].last = 1'b1;
    first  = got[0];
    second = got[1];
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : result_check
    mbps_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat kind=%0b addr=%h count=%0d last=%0b",
                                out_tuser, out_tdata[31:0], out_tdata[47:32], out_tlast));
      end else begin
        want = awaited_results.pop_front();
        if (out_tuser !== want.kind)
          flag_mismatch($sformatf("kind got %0b want %0b", out_tuser, want.kind));
        if (out_tdata[31:0] !== want.addr)
          flag_mismatch($sformatf("address got %h want %h", out_tdata[31:0], want.addr));
        if (out_tdata[47:32] !== want.count)
          flag_mismatch($sformatf("count got %0d want %0d", out_tdata[47:32], want.count));
        if (out_tlast !== want.last)
          flag_mismatch($sformatf("tlast got %0b want %0b", out_tlast, want.last));
      end
    end
  end

  // Receiver: random stalls between ready runs; always ready when idling is off.
  initial begin : result_backpressure
    int hold;
    out_tready = 1'b0;
    hold       = 0;
    forever begin
      @(negedge clk);
      if (!idling_on) begin
        out_tready = 1'b1;
      end else if (hold > 0) begin
        hold--;
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready = 1'b0;
        hold       = $urandom_range(0, 18);
      end else begin
        out_tready = 1'b1;
        hold       = $urandom_range(0, 24);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Register write: one cycle of cfg_we, mirrored into the predictor at the edge.
  task automatic write_reg(input logic [mbps_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [63:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    case (idx)
      mbps_pkg::REG_PAT_LO: pat_lo_r = val;
      mbps_pkg::REG_PAT_HI: pat_hi_r = val;
      mbps_pkg::REG_CARE:   care_r   = val[15:0];
      mbps_pkg::REG_LEN:    len_r    = val[4:0];
      mbps_pkg::REG_MAX:    max_r    = val[15:0];
      mbps_pkg::REG_BASE:   base_r   = val[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One input beat, preceded now and then by an idle gap. At the accepting
  // edge the expected results go into the queue: typed ones if given, else predicted.
  task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input logic [1:0] typed_n, input mbps_pkg::res_t t0,
                           input mbps_pkg::res_t t1);
    int             gap;
    int             n;
    mbps_pkg::res_t p0;
    mbps_pkg::res_t p1;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = fin;
    do @(posedge clk); while (!in_tready);
    n = scan_byte_results(b, fin, p0, p1);
    if (typed) begin
      n  = typed_n;
      p0 = t0;
      p1 = t1;
    end
    if (n > 0) awaited_results = {awaited_results, p0};
    if (n > 1) awaited_results = {awaited_results, p1};
  endtask

  // Drop valid and wait until every expected beat is back, plus a short margin.
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Image bytes: planted pattern copies (wildcard bytes random, some copies
  // cut short), near misses built from pattern bytes, and plain noise.
  function automatic logic [7:0] next_image_byte();
    int unsigned span;
    int unsigned j;
    span = pattern_span();
    if (plant_at >= span && $urandom_range(0, 5) == 0) plant_at = 0;
    if (plant_at < span) begin
      j = plant_at;
      plant_at++;
      if ($urandom_range(0, 24) == 0) begin
        plant_at = MAX_SPAN;
        return 8'($urandom);
      end
      return care_r[j] ? pattern_byte(j) : 8'($urandom);
    end
    if ($urandom_range(0, 3) == 0) return pattern_byte($urandom_range(0, span - 1));
    return 8'($urandom);
  endfunction

  task automatic pick_settings();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] v;
    logic [7:0]  fill;
    fill = 8'($urandom);
    case ($urandom_range(0, 5))
      0: begin lo = '0; hi = '0; end
      1: begin lo = '1; hi = '1; end
      2: begin lo = {8{fill}}; hi = {8{fill}}; end   // one byte everywhere: overlapping hits
      default: begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
    endcase
    write_reg(mbps_pkg::REG_PAT_LO, lo);
    write_reg(mbps_pkg::REG_PAT_HI, hi);

    case ($urandom_range(0, 5))
      0: v = 64'h0;
      1: v = 64'hFFFF;
      2: v = 64'($urandom & $urandom & 32'hFFFF);
      default: v = 64'($urandom_range(0, 16'hFFFF));
    endcase
    write_reg(mbps_pkg::REG_CARE, v);

    case ($urandom_range(0, 9))
      0: v = 64'd0;
      1: v = 64'($urandom_range(17, 31));
      2: v = 64'd16;
      3: v = 64'd1;
      4, 5: v = 64'($urandom_range(9, 15));
      default: v = 64'($urandom_range(2, 8));
    endcase
    write_reg(mbps_pkg::REG_LEN, v);

    case ($urandom_range(0, 7))
      0: v = 64'd0;
      1, 2: v = 64'($urandom_range(1, 3));
      3: v = 64'($urandom_range(0, 16'hFFFF));
      default: v = 64'hFFFF;
    endcase
    write_reg(mbps_pkg::REG_MAX, v);

    case ($urandom_range(0, 5))
      0: v = 64'h0;
      1: v = 64'hFFFF_FFFF;
      2: v = 64'(32'hFFFF_FFFF - $urandom_range(0, 40));   // match addresses wrap
      default: v = 64'($urandom);
    endcase
    write_reg(mbps_pkg::REG_BASE, v);
  endtask

  // ---------------------------------------------------------------------------
  // Directed script. Rows with typed = 1 carry the expected beats; the rest are
  // checked against the predictor.
  // ---------------------------------------------------------------------------
  typedef enum logic {ROW_BYTE, ROW_WRITE} row_op_t;

  typedef struct packed {
    row_op_t                             op;
    logic [mbps_pkg::CFG_INDEX_BITS-1:0] reg_idx;
    logic [63:0]                         value;
    logic [7:0]                          data;
    logic                                fin;
    logic                                typed;
    logic [1:0]                          n_res;
    mbps_pkg::res_t                      r0;
    mbps_pkg::res_t                      r1;
  } script_row_t;

  localparam int SCRIPT_ROWS = 31;

  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    // reset values: length 1, all wildcard, limit 1, base 0; offset zero hit is reported
    '{ROW_BYTE, mbps_pkg::REG_PAT_LO, 64'h0, 8'h00, 1'b0, 1'b1, 2'd1,
      '{mbps_pkg::KIND_MATCH, 32'h0, 16'd1, 1'b1}, NO_RES},
    '{ROW_BYTE, mbps_pkg::REG_PAT_LO, 64'h0, 8'hFF, 1'b0, 1'b1, 2'd0,
      NO_RES, NO_RES},                                                         // limit hit
    '{ROW_BYTE, mbps_pkg::REG_PAT_LO, 64'h0, 8'h5A, 1'b1, 1'b1, 2'd1,
      '{mbps_pkg::KIND_SUMMARY, 32'h0, 16'd1, 1'b1}, NO_RES},
    // one-byte image: match and summary from the same beat
    '{ROW_BYTE, mbps_pkg::REG_PAT_LO, 64'h0, 8'hA5, 1'b1, 1'b1, 2'd2,
      '{mbps_pkg::KIND_MATCH, 32'h0, 16'd1, 1'b0},
      '{mbps_pkg::KIND_SUMMARY, 32'h0, 16'd1, 1'b1}},
    // DE AD BE EF, exact, limit 3, base just below the 32-bit wrap
    '{ROW_WRITE, mbps_pkg::REG_PAT_LO, 64'h0000_0000_EFBE_ADDE, 8'h0, 1'b0, 1'b0, 2'd0,
      NO_RES, NO_RES},
    '{ROW_WRITE, mbps_pkg::REG_PAT_HI, 64'hFFFF_FFFF_FFFF_FFFF, 8'h0, 1'b0, 1'b0, 2'd0,
      NO_RES, NO_RES},
    '{ROW_WRITE, mbps_pkg::REG_CARE, 64'h000F, 8'h0, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_WRITE, mbps_pkg::REG_LEN,  64'd4,    8'h0, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_WRITE, mbps_pkg::REG_MAX,  64'd3,    8'h0, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_WRITE, mbps_pkg::REG_BASE, 64'hFFFF_FFFE, 8'h0, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_BYTE, mbps_pkg::REG_PAT_LO, 64'h0, 8'hDE, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{ROW_BYTE, mbps_pkg::REG_PAT_LO, 64'h0, 8'hAD, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{ROW_BYTE, mbps_pkg::REG_PAT_LO, 64'h0, 8'hBE, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{ROW_BYTE, mbps_pkg::REG_PAT_LO, 64'h0, 8'hEF, 1'b0, 1'b1, 2'd1,
      '{mbps_pkg::KIND_MATCH, 32'hFFFF_FFFE, 16'd1, 1'b1}, NO_RES},
    '{ROW_BYTE, mbps_pkg::REG_PAT_LO, 64'h0, 8'hDE, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{ROW_BYTE, mbps_pkg::REG_PAT_LO, 64'h0, 8'hAD, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{ROW_BYTE, mbps_pkg::REG_PAT_LO, 64'h0, 8'hBE, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{ROW_BYTE, mbps_pkg::REG_PAT_LO, 64'h0, 8'hEF, 1'b0, 1'b1, 2'd1,
      '{mbps_pkg::KIND_MATCH, 32'h0000_0002, 16'd2, 1'b1}, NO_RES},           // address wraps
    '{ROW_BYTE, mbps_pkg::REG_PAT_LO, 64'h0, 8'h00, 1'b1, 1'b1, 2'd1,
      '{mbps_pkg::KIND_SUMMARY, 32'h0, 16'd2, 1'b1}, NO_RES},
    // only the last byte cared for: a one-byte image is still too short
    '{ROW_WRITE, mbps_pkg::REG_CARE, 64'h0008, 8'h0, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_BYTE, mbps_pkg::REG_PAT_LO, 64'h0, 8'hEF, 1'b1, 1'b1, 2'd1,
      '{mbps_pkg::KIND_SUMMARY, 32'h0, 16'd0, 1'b1}, NO_RES},
    // length 0 acts as 1, care bits past the length ignored, limit 0 reports nothing
    '{ROW_WRITE, mbps_pkg::REG_LEN,  64'd0,    8'h0, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_WRITE, mbps_pkg::REG_CARE, 64'hFFFE, 8'h0, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_WRITE, mbps_pkg::REG_MAX,  64'd0,    8'h0, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_BYTE, mbps_pkg::REG_PAT_LO, 64'h0, 8'h33, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{ROW_BYTE, mbps_pkg::REG_PAT_LO, 64'h0, 8'hCC, 1'b1, 1'b1, 2'd1,
      '{mbps_pkg::KIND_SUMMARY, 32'h0, 16'd0, 1'b1}, NO_RES},
    // "?? AD" over AD AD AD: overlapping hits at the top of the address space
    '{ROW_WRITE, mbps_pkg::REG_MAX,  64'hFFFF, 8'h0, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_WRITE, mbps_pkg::REG_LEN,  64'd2,    8'h0, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_BYTE, mbps_pkg::REG_PAT_LO, 64'h0, 8'hAD, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_BYTE, mbps_pkg::REG_PAT_LO, 64'h0, 8'hAD, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_BYTE, mbps_pkg::REG_PAT_LO, 64'h0, 8'hAD, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    bit          dirty;
    int unsigned bytes_sent;
    int unsigned scans;
    int unsigned scan_len;
    int unsigned k;
    bit          open_end;

    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = mbps_pkg::REG_PAT_LO;
    cfg_wdata = '0;
    rst_n     = 1'b0;

    pat_lo_r = '0;
    pat_hi_r = '0;
    care_r   = '0;
    len_r    = mbps_pkg::LEN_RESET;
    max_r    = mbps_pkg::MAX_RESET;
    base_r   = '0;
    restart_scan();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: writes only once all earlier beats are back
    dirty = 1'b0;
    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      if (SCRIPT[r].op == ROW_WRITE) begin
        if (dirty) settle();
        dirty = 1'b0;
        write_reg(SCRIPT[r].reg_idx, SCRIPT[r].value);
      end else begin
        send_byte(SCRIPT[r].data, SCRIPT[r].fin, SCRIPT[r].typed, SCRIPT[r].n_res,
                  SCRIPT[r].r0, SCRIPT[r].r1);
        dirty = 1'b1;
      end
    end

    // random phases: new settings, then a few images; some phases leave the last
    // image open so the scan carries on under the next settings
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      settle();
      pick_settings();
      idling_on = (bytes_sent + QUIET_TAIL < RANDOM_BYTES) && ($urandom_range(0, 3) != 0);
      scans     = $urandom_range(1, 4);
      open_end  = ($urandom_range(0, 3) == 0);
      for (int unsigned s = 0; s < scans; s++) begin
        scan_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 60);
        for (k = 0; k < scan_len; k++) begin
          // the tail of the run goes without idling on either side
          if (bytes_sent + QUIET_TAIL >= RANDOM_BYTES) idling_on = 1'b0;
          send_byte(next_image_byte(), (k == scan_len - 1) && !(open_end && s == scans - 1),
                    1'b0, 2'd0, NO_RES, NO_RES);
          bytes_sent++;
        end
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (~1.8k beats, each with the longest
  // gap, two results behind the longest stalls, plus settle time per phase).
  initial begin : watchdog
    #(10_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
